### rtl/core/ioapic_irq_router_defines.svh
// Assertion macros used by the interrupt router top level.
`ifndef IOAPIC_IRQ_ROUTER_DEFINES_SVH
`define IOAPIC_IRQ_ROUTER_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted (active-low reset).
`define IOAPIC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// Clocked check that also holds during reset.
`define IOAPIC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IOAPIC_ASSERT(lbl, clk, rstn, prop, msg)
`define IOAPIC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/ioapic_pkg.sv
// Shared types and constants of the I/O APIC interrupt router.
package ioapic_pkg;

  localparam int OVERRIDE_ENTRIES = 16;
  localparam int CONTROLLERS      = 8;

  localparam int OVR_IDX_W = (OVERRIDE_ENTRIES > 1) ? $clog2(OVERRIDE_ENTRIES) : 1;
  localparam int CTL_IDX_W = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;

  localparam logic [7:0] REDIR_BASE     = 8'h10;
  localparam logic [1:0] FLAG_FIELD_ALL = 2'b11;
  localparam int         POL_LOW_BIT    = 13;
  localparam int         TRIG_LEVEL_BIT = 15;
  localparam int         MASK_BIT       = 16;

  typedef enum logic [1:0] {
    FUNC_LOAD_OVR  = 2'd0,
    FUNC_LOAD_CTL  = 2'd1,
    FUNC_ROUTE_IRQ = 2'd2,
    FUNC_MASK_IRQ  = 2'd3
  } func_e;

  // Registered override table read.
  typedef struct packed {
    logic        hit;
    logic [31:0] gsi;
    logic [3:0]  flags;
  } ovr_rd_t;

  // Result of one controller range compare.
  typedef struct packed {
    logic       hit;
    logic [7:0] pin;
  } ctl_hit_t;

endpackage

### rtl/core/ioapic_irq_router.sv
// I/O APIC interrupt router top level: sequencer, item registers and result port.
//
// Load override and load controller transactions update the tables without
// leaving the idle state. A route or mask transaction first reads the
// override table, then scans the controller table one slot per cycle through a
// single subtract/compare unit until the first covering controller or the last
// slot, then presents its results: two for a routed hit, one otherwise.
// A route or mask transaction therefore occupies the block until its last result
// is taken; in_stall_o is high for that whole time. The valid bits of both tables
// are cleared by reset.
module ioapic_irq_router (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [2:0]  slot_i,
  input  logic [7:0]  irq_i,
  input  logic [7:0]  bus_i,
  input  logic [31:0] gsi_i,
  input  logic [15:0] flags_i,
  input  logic [31:0] base_gsi_i,
  input  logic [7:0]  max_redir_i,
  input  logic [7:0]  vector_i,
  input  logic [7:0]  dest_id_i,
  input  logic        masked_i,
  input  logic        valid_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [2:0]  controller_o,
  output logic [7:0]  reg_select_o,
  output logic [31:0] data_o,
  output logic        mask_only_o,
  output logic        last_o
);
  import ioapic_pkg::*;
  `include "ioapic_irq_router_defines.svh"

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOOKUP = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_RES_HI = 5'b01000,
    ST_RES_LO = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [CTL_IDX_W-1:0] idx_q, idx_d;

  func_e                func_q;
  logic [7:0]           irq_q;
  logic [7:0]           vector_q;
  logic [7:0]           dest_q;
  logic                 masked_q;
  logic [31:0]          g_q;
  logic [3:0]           flg_q;
  logic                 found_q;
  logic [CTL_IDX_W-1:0] slot_q;
  logic [7:0]           pin_q;

  func_e                in_func;
  logic                 in_accept;
  logic                 out_accept;
  ovr_rd_t              ovr_rd;
  ctl_hit_t             scan;
  logic                 scan_last;
  logic [7:0]           reg_lo;
  logic [31:0]          low_word;

  assign in_func    = func_e'(func_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_RES_HI) || (state_q == ST_RES_LO);
  assign out_accept = out_valid_o && !out_stall_i;
  assign scan_last  = (idx_q == CTL_IDX_W'(CONTROLLERS - 1));

  ioapic_ovr_table u_ovr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (in_accept && (in_func == FUNC_LOAD_OVR) && (bus_i == 8'd0)),
    .wr_irq_i   (irq_i),
    .wr_gsi_i   (gsi_i),
    .wr_flags_i (flags_i[3:0]),
    .rd_en_i    (in_accept),
    .rd_irq_i   (irq_i),
    .rd_o       (ovr_rd)
  );

  ioapic_ctl_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_en_i        (in_accept && (in_func == FUNC_LOAD_CTL)),
    .wr_slot_i      (slot_i),
    .wr_valid_i     (valid_req_i),
    .wr_base_i      (base_gsi_i),
    .wr_max_redir_i (max_redir_i),
    .scan_idx_i     (idx_q),
    .scan_gsi_i     (g_q),
    .scan_o         (scan)
  );

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && ((in_func == FUNC_ROUTE_IRQ) || (in_func == FUNC_MASK_IRQ))) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        idx_d   = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan.hit) begin
          state_d = (func_q == FUNC_ROUTE_IRQ) ? ST_RES_HI : ST_RES_LO;
        end else if (scan_last) begin
          state_d = ST_RES_LO;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_RES_HI: begin
        if (out_accept) begin
          state_d = ST_RES_LO;
        end
      end
      ST_RES_LO: begin
        if (out_accept) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (state_q == ST_LOOKUP) begin
        found_q <= 1'b0;
      end else if ((state_q == ST_SCAN) && scan.hit) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q   <= in_func;
      irq_q    <= irq_i;
      vector_q <= vector_i;
      dest_q   <= dest_id_i;
      masked_q <= masked_i;
    end
    if (state_q == ST_LOOKUP) begin
      g_q   <= ovr_rd.hit ? ovr_rd.gsi : {24'd0, irq_q};
      flg_q <= ovr_rd.hit ? ovr_rd.flags : 4'd0;
    end
    if ((state_q == ST_SCAN) && scan.hit) begin
      slot_q <= idx_q;
      pin_q  <= scan.pin;
    end
  end

  assign reg_lo = REDIR_BASE + {pin_q[6:0], 1'b0};

  always_comb begin
    low_word                 = {24'd0, vector_q};
    low_word[POL_LOW_BIT]    = (flg_q[1:0] == FLAG_FIELD_ALL);
    low_word[TRIG_LEVEL_BIT] = (flg_q[3:2] == FLAG_FIELD_ALL);
  end

  always_comb begin
    found_o      = found_q;
    controller_o = 3'd0;
    reg_select_o = 8'd0;
    data_o       = 32'd0;
    mask_only_o  = 1'b0;
    last_o       = (state_q == ST_RES_LO);
    if (found_q) begin
      controller_o = 3'(slot_q);
      if (state_q == ST_RES_HI) begin
        reg_select_o = reg_lo + 8'd1;
        data_o       = {dest_q, 24'd0};
      end else if (func_q == FUNC_MASK_IRQ) begin
        reg_select_o      = reg_lo;
        data_o[MASK_BIT]  = masked_q;
        mask_only_o       = 1'b1;
      end else begin
        reg_select_o = reg_lo;
        data_o       = low_word;
      end
    end
  end

  `IOAPIC_ASSERT(a_busy_while_output, clk_i, rst_ni, out_valid_o |-> in_stall_o, "input taken while a result is pending")
  `IOAPIC_ASSERT(a_hi_then_lo, clk_i, rst_ni, (state_q == ST_RES_HI) && !out_stall_i |=> (state_q == ST_RES_LO) && last_o, "high word not followed by low word")
  `IOAPIC_ASSERT(a_first_is_hit, clk_i, rst_ni, out_valid_o && !last_o |-> found_o && !mask_only_o, "non-final result without a routed hit")
  `IOAPIC_ASSERT(a_miss_zero, clk_i, rst_ni, out_valid_o && !found_o |-> (data_o == 32'd0) && (reg_select_o == 8'd0) && last_o, "miss result carries payload")
  `IOAPIC_ASSERT_ALWAYS(a_scan_bounded, clk_i, (state_q == ST_SCAN) |-> (int'(idx_q) < CONTROLLERS), "scan index past controller table")

endmodule

### rtl/core/ioapic_ovr_table.sv
// ISA source override table with valid bits and a registered read port.
module ioapic_ovr_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [7:0]           wr_irq_i,
  input  logic [31:0]          wr_gsi_i,
  input  logic [3:0]           wr_flags_i,
  input  logic                 rd_en_i,
  input  logic [7:0]           rd_irq_i,
  output ioapic_pkg::ovr_rd_t  rd_o
);
  import ioapic_pkg::*;

  logic [OVERRIDE_ENTRIES-1:0] valid_q;
  logic [31:0]                 gsi_q   [OVERRIDE_ENTRIES];
  logic [3:0]                  flags_q [OVERRIDE_ENTRIES];
  ovr_rd_t                     rd_q;
  logic                        wr_in_range;
  logic                        rd_in_range;
  logic [OVR_IDX_W-1:0]        wr_idx;
  logic [OVR_IDX_W-1:0]        rd_idx;

  assign wr_in_range = {1'b0, wr_irq_i} < 9'(OVERRIDE_ENTRIES);
  assign rd_in_range = {1'b0, rd_irq_i} < 9'(OVERRIDE_ENTRIES);
  assign wr_idx      = OVR_IDX_W'(wr_irq_i);
  assign rd_idx      = OVR_IDX_W'(rd_irq_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i && wr_in_range) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_in_range) begin
      gsi_q[wr_idx]   <= wr_gsi_i;
      flags_q[wr_idx] <= wr_flags_i;
    end
    if (rd_en_i) begin
      rd_q.hit   <= rd_in_range && valid_q[rd_idx];
      rd_q.gsi   <= gsi_q[rd_idx];
      rd_q.flags <= flags_q[rd_idx];
    end
  end

  assign rd_o = rd_q;

endmodule

### rtl/core/ioapic_ctl_scan.sv
// Controller range table and the shared subtract/compare unit used by the scan.
module ioapic_ctl_scan (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [2:0]                         wr_slot_i,
  input  logic                               wr_valid_i,
  input  logic [31:0]                        wr_base_i,
  input  logic [7:0]                         wr_max_redir_i,
  input  logic [ioapic_pkg::CTL_IDX_W-1:0]   scan_idx_i,
  input  logic [31:0]                        scan_gsi_i,
  output ioapic_pkg::ctl_hit_t               scan_o
);
  import ioapic_pkg::*;

  logic [CONTROLLERS-1:0] valid_q;
  logic [31:0]            base_q [CONTROLLERS];
  logic [8:0]             pins_q [CONTROLLERS];
  logic                   wr_in_range;
  logic [CTL_IDX_W-1:0]   wr_idx;
  logic [32:0]            diff;
  logic                   in_range;

  assign wr_in_range = int'(wr_slot_i) < CONTROLLERS;
  assign wr_idx      = CTL_IDX_W'(wr_slot_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i && wr_in_range) begin
      valid_q[wr_idx] <= wr_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_in_range) begin
      base_q[wr_idx] <= wr_base_i;
      pins_q[wr_idx] <= {1'b0, wr_max_redir_i} + 9'd1;
    end
  end

  // borrow out means gsi below base
  assign diff     = {1'b0, scan_gsi_i} - {1'b0, base_q[scan_idx_i]};
  assign in_range = !diff[32] && (diff[31:9] == '0) && (diff[8:0] < pins_q[scan_idx_i]);

  assign scan_o.hit = valid_q[scan_idx_i] && in_range;
  assign scan_o.pin = diff[7:0];

endmodule

### tb/ioapic_irq_router_checker.sv
// Checker for the I/O APIC interrupt router: table model, expected register writes, compare.
module ioapic_irq_router_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  func_i,
  input  logic [2:0]  slot_i,
  input  logic [7:0]  irq_i,
  input  logic [7:0]  bus_i,
  input  logic [31:0] gsi_i,
  input  logic [15:0] flags_i,
  input  logic [31:0] base_gsi_i,
  input  logic [7:0]  max_redir_i,
  input  logic [7:0]  vector_i,
  input  logic [7:0]  dest_id_i,
  input  logic        masked_i,
  input  logic        valid_req_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        found_i,
  input  logic [2:0]  controller_i,
  input  logic [7:0]  reg_select_i,
  input  logic [31:0] data_i,
  input  logic        mask_only_i,
  input  logic        last_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          results_o
);
  import ioapic_pkg::*;

  typedef struct packed {
    logic        found;
    logic [2:0]  controller;
    logic [7:0]  reg_select;
    logic [31:0] data;
    logic        mask_only;
    logic        last;
  } redir_write_t;

  redir_write_t redir_write_q[$];
  redir_write_t oldest_write;

  logic        ovr_valid [OVERRIDE_ENTRIES];
  logic [31:0] ovr_gsi   [OVERRIDE_ENTRIES];
  logic [15:0] ovr_flags [OVERRIDE_ENTRIES];
  logic        ctl_valid [CONTROLLERS];
  logic [31:0] ctl_base  [CONTROLLERS];
  logic [8:0]  ctl_pins  [CONTROLLERS];

  int mismatch_count;
  int write_count;

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch on write %0d: %s", $time, write_count, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Updates the tables or queues the register writes that one transaction causes.
  task automatic predict_redirection();
    logic [31:0]  gsi_res;
    logic [31:0]  low_word;
    logic [15:0]  ovr_flg;
    logic         hit;
    logic [2:0]   owner;
    logic [7:0]   pin;
    logic [7:0]   entry_reg;
    redir_write_t w;
    case (func_e'(func_i))
      FUNC_LOAD_OVR: begin
        if (bus_i == 8'd0 && irq_i < OVERRIDE_ENTRIES) begin
          ovr_valid[irq_i] = 1'b1;
          ovr_gsi[irq_i]   = gsi_i;
          ovr_flags[irq_i] = flags_i;
        end
      end
      FUNC_LOAD_CTL: begin
        if (slot_i < CONTROLLERS) begin
          ctl_valid[slot_i] = valid_req_i;
          ctl_base[slot_i]  = base_gsi_i;
          ctl_pins[slot_i]  = {1'b0, max_redir_i} + 9'd1;
        end
      end
      default: begin
        gsi_res = {24'h0, irq_i};
        ovr_flg = '0;
        hit     = 1'b0;
        owner   = '0;
        pin     = '0;
        if (irq_i < OVERRIDE_ENTRIES && ovr_valid[irq_i]) begin
          gsi_res = ovr_gsi[irq_i];
          ovr_flg = ovr_flags[irq_i];
        end
        for (int i = 0; i < CONTROLLERS; i++) begin
          if (!hit && ctl_valid[i] && ctl_pins[i] != 9'd0 && gsi_res >= ctl_base[i]
              && (gsi_res - ctl_base[i]) < {23'h0, ctl_pins[i]}) begin
            hit   = 1'b1;
            owner = 3'(i);
            pin   = 8'(gsi_res - ctl_base[i]);
          end
        end
        entry_reg = REDIR_BASE + {pin[6:0], 1'b0};
        w = '0;
        w.last = 1'b1;
        if (!hit) begin
          redir_write_q.push_back(w);
        end else if (func_e'(func_i) == FUNC_ROUTE_IRQ) begin
          w.found      = 1'b1;
          w.controller = owner;
          w.reg_select = entry_reg + 8'd1;
          w.data       = {dest_id_i, 24'h0};
          w.last       = 1'b0;
          redir_write_q.push_back(w);
          low_word = {24'h0, vector_i};
          low_word[POL_LOW_BIT]    = (ovr_flg[1:0] == FLAG_FIELD_ALL);
          low_word[TRIG_LEVEL_BIT] = (ovr_flg[3:2] == FLAG_FIELD_ALL);
          low_word[MASK_BIT]       = 1'b0;
          w.reg_select = entry_reg;
          w.data       = low_word;
          w.last       = 1'b1;
          redir_write_q.push_back(w);
        end else begin
          w.found      = 1'b1;
          w.controller = owner;
          w.reg_select = entry_reg;
          w.data       = '0;
          w.data[MASK_BIT] = masked_i;
          w.mask_only  = 1'b1;
          redir_write_q.push_back(w);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < OVERRIDE_ENTRIES; i++) begin
        ovr_valid[i] = 1'b0;
        ovr_gsi[i]   = '0;
        ovr_flags[i] = '0;
      end
      for (int i = 0; i < CONTROLLERS; i++) begin
        ctl_valid[i] = 1'b0;
        ctl_base[i]  = '0;
        ctl_pins[i]  = '0;
      end
      redir_write_q.delete();
      mismatch_count = 0;
      write_count    = 0;
      mismatches_o  <= 0;
      pending_o     <= 0;
      results_o     <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_redirection();
      end
      if (out_valid_i && !out_stall_i) begin
        write_count++;
        if (redir_write_q.size() == 0) begin
          note_mismatch("result with nothing expected");
        end else begin
          oldest_write = redir_write_q.pop_front();
          check_field("found", {31'h0, found_i}, {31'h0, oldest_write.found});
          check_field("controller", {29'h0, controller_i}, {29'h0, oldest_write.controller});
          check_field("reg_select", {24'h0, reg_select_i}, {24'h0, oldest_write.reg_select});
          check_field("data", data_i, oldest_write.data);
          check_field("mask_only", {31'h0, mask_only_i}, {31'h0, oldest_write.mask_only});
          check_field("last", {31'h0, last_i}, {31'h0, oldest_write.last});
        end
      end
      mismatches_o <= mismatch_count;
      pending_o    <= redir_write_q.size();
      results_o    <= write_count;
    end
  end

endmodule

### tb/ioapic_irq_router_tb.sv
// Testbench top for the I/O APIC interrupt router: clock, reset, stimulus and verdict.
module ioapic_irq_router_tb;
  import ioapic_pkg::*;

  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 1225;
  localparam int CALM_FIRST     = 300;
  localparam int CALM_LAST      = 500;
  localparam int HOLD_AT        = 700;
  localparam int HOLD_LEN       = 400;
  localparam int IDLE_PCT       = 36;
  localparam int DRAIN_CYCLES   = 30;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    func_e       func;
    logic [2:0]  slot;
    logic [7:0]  irq;
    logic [7:0]  bus;
    logic [31:0] gsi;
    logic [15:0] flags;
    logic [31:0] base_gsi;
    logic [7:0]  max_redir;
    logic [7:0]  vector;
    logic [7:0]  dest_id;
    logic        masked;
    logic        valid_req;
  } irq_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  func_i;
  logic [2:0]  slot_i;
  logic [7:0]  irq_i;
  logic [7:0]  bus_i;
  logic [31:0] gsi_i;
  logic [15:0] flags_i;
  logic [31:0] base_gsi_i;
  logic [7:0]  max_redir_i;
  logic [7:0]  vector_i;
  logic [7:0]  dest_id_i;
  logic        masked_i;
  logic        valid_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        found_o;
  logic [2:0]  controller_o;
  logic [7:0]  reg_select_o;
  logic [31:0] data_o;
  logic        mask_only_o;
  logic        last_o;

  int mismatches;
  int pending_writes;
  int writes_checked;
  int items_sent;
  int quiet_cycles;
  bit calm;
  bit held;

  ioapic_irq_router u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .slot_i       (slot_i),
    .irq_i        (irq_i),
    .bus_i        (bus_i),
    .gsi_i        (gsi_i),
    .flags_i      (flags_i),
    .base_gsi_i   (base_gsi_i),
    .max_redir_i  (max_redir_i),
    .vector_i     (vector_i),
    .dest_id_i    (dest_id_i),
    .masked_i     (masked_i),
    .valid_req_i  (valid_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .controller_o (controller_o),
    .reg_select_o (reg_select_o),
    .data_o       (data_o),
    .mask_only_o  (mask_only_o),
    .last_o       (last_o)
  );

  ioapic_irq_router_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .func_i       (func_i),
    .slot_i       (slot_i),
    .irq_i        (irq_i),
    .bus_i        (bus_i),
    .gsi_i        (gsi_i),
    .flags_i      (flags_i),
    .base_gsi_i   (base_gsi_i),
    .max_redir_i  (max_redir_i),
    .vector_i     (vector_i),
    .dest_id_i    (dest_id_i),
    .masked_i     (masked_i),
    .valid_req_i  (valid_req_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_i      (found_o),
    .controller_i (controller_o),
    .reg_select_i (reg_select_o),
    .data_i       (data_o),
    .mask_only_i  (mask_only_o),
    .last_i       (last_o),
    .mismatches_o (mismatches),
    .pending_o    (pending_writes),
    .results_o    (writes_checked)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic irq_item_t random_fill();
    irq_item_t it;
    it.func      = func_e'($urandom_range(3));
    it.slot      = 3'($urandom);
    it.irq       = 8'($urandom);
    it.bus       = 8'($urandom);
    it.gsi       = $urandom;
    it.flags     = 16'($urandom);
    it.base_gsi  = $urandom;
    it.max_redir = 8'($urandom);
    it.vector    = 8'($urandom);
    it.dest_id   = 8'($urandom);
    it.masked    = 1'($urandom);
    it.valid_req = 1'($urandom);
    return it;
  endfunction

  function automatic irq_item_t ovr_load(input logic [7:0] irq, input logic [7:0] bus,
                                         input logic [31:0] gsi, input logic [15:0] flags);
    irq_item_t it;
    it       = random_fill();
    it.func  = FUNC_LOAD_OVR;
    it.irq   = irq;
    it.bus   = bus;
    it.gsi   = gsi;
    it.flags = flags;
    return it;
  endfunction

  function automatic irq_item_t ctl_load(input logic [2:0] slot, input logic [31:0] base,
                                         input logic [7:0] max_redir, input logic vreq);
    irq_item_t it;
    it           = random_fill();
    it.func      = FUNC_LOAD_CTL;
    it.slot      = slot;
    it.base_gsi  = base;
    it.max_redir = max_redir;
    it.valid_req = vreq;
    return it;
  endfunction

  function automatic irq_item_t irq_op(input func_e f, input logic [7:0] irq,
                                       input logic [7:0] vector, input logic [7:0] dest,
                                       input logic masked);
    irq_item_t it;
    it           = random_fill();
    it.func      = f;
    it.irq       = irq;
    it.vector    = vector;
    it.dest_id   = dest;
    it.masked    = masked;
    return it;
  endfunction

  // GSI windows shared by overrides and controllers so that lookups hit often.
  function automatic logic [31:0] gsi_window();
    case ($urandom_range(4))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0100;
      2:       return 32'h8000_0000;
      3:       return 32'hffff_ff00;
      default: return $urandom;
    endcase
  endfunction

  function automatic irq_item_t random_item();
    irq_item_t it;
    int pick;
    it   = random_fill();
    pick = $urandom_range(99);
    if (pick < 12) begin
      it.func = FUNC_LOAD_OVR;
      it.bus  = ($urandom_range(99) < 85) ? 8'd0 : 8'($urandom_range(255, 1));
      it.irq  = ($urandom_range(99) < 85) ? 8'($urandom_range(15)) : 8'($urandom);
      it.gsi  = ($urandom_range(99) < 85) ? gsi_window() + $urandom_range(300) : $urandom;
    end else if (pick < 24) begin
      it.func      = FUNC_LOAD_CTL;
      it.base_gsi  = gsi_window() + $urandom_range(64);
      it.max_redir = ($urandom_range(99) < 80) ? 8'($urandom_range(31)) : 8'($urandom);
      it.valid_req = ($urandom_range(99) < 85);
    end else begin
      it.func = (pick < 70) ? FUNC_ROUTE_IRQ : FUNC_MASK_IRQ;
      it.irq  = ($urandom_range(99) < 60) ? 8'($urandom_range(15)) : 8'($urandom);
    end
    return it;
  endfunction

  task automatic drive_item(input irq_item_t it);
    logic stall_seen;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= it.func;
    slot_i      <= it.slot;
    irq_i       <= it.irq;
    bus_i       <= it.bus;
    gsi_i       <= it.gsi;
    flags_i     <= it.flags;
    base_gsi_i  <= it.base_gsi;
    max_redir_i <= it.max_redir;
    vector_i    <= it.vector;
    dest_id_i   <= it.dest_id;
    masked_i    <= it.masked;
    valid_req_i <= it.valid_req;
    do begin
      @(negedge clk_i);
      stall_seen = in_stall_o;
      @(posedge clk_i);
    end while (stall_seen);
    items_sent++;
  endtask

  // Receiver: random stalls, one long hold-off so the block backs up into its input.
  initial begin
    out_stall_i = 1'b0;
    held        = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && items_sent >= HOLD_AT) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_LEN - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    calm         = 1'b0;
    items_sent   = 0;
    quiet_cycles = 0;
    in_valid_i  <= 1'b0;
    func_i      <= FUNC_LOAD_OVR;
    slot_i      <= '0;
    irq_i       <= '0;
    bus_i       <= '0;
    gsi_i       <= '0;
    flags_i     <= '0;
    base_gsi_i  <= '0;
    max_redir_i <= '0;
    vector_i    <= '0;
    dest_id_i   <= '0;
    masked_i    <= 1'b0;
    valid_req_i <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty tables: misses; then slot 0 covers GSI 0..23: two hits and one miss
    drive_item(irq_op(FUNC_ROUTE_IRQ, 8'd0, 8'h00, 8'h00, 1'b0));
    drive_item(irq_op(FUNC_MASK_IRQ, 8'd255, 8'hff, 8'hff, 1'b1));
    drive_item(ctl_load(3'd0, 32'd0, 8'd23, 1'b1));
    drive_item(irq_op(FUNC_ROUTE_IRQ, 8'd0, 8'h20, 8'h00, 1'b0));
    drive_item(irq_op(FUNC_ROUTE_IRQ, 8'd23, 8'hff, 8'hff, 1'b0));
    drive_item(irq_op(FUNC_ROUTE_IRQ, 8'd24, 8'h30, 8'h01, 1'b0));
    // full 256-pin controller at the top of the GSI space; pin 255 wraps the register index
    drive_item(ctl_load(3'd1, 32'hffff_ff00, 8'd255, 1'b1));
    drive_item(ovr_load(8'd15, 8'd0, 32'hffff_ffff, 16'h000f));
    drive_item(irq_op(FUNC_ROUTE_IRQ, 8'd15, 8'hff, 8'hff, 1'b0));
    drive_item(irq_op(FUNC_MASK_IRQ, 8'd15, 8'h00, 8'h00, 1'b1));
    // override on a nonzero bus and beyond the table: both dropped
    drive_item(ovr_load(8'd5, 8'd1, 32'hffff_ff00, 16'hffff));
    drive_item(irq_op(FUNC_ROUTE_IRQ, 8'd5, 8'h41, 8'h7f, 1'b0));
    drive_item(ovr_load(8'd16, 8'd0, 32'hffff_ff01, 16'hffff));
    drive_item(irq_op(FUNC_ROUTE_IRQ, 8'd16, 8'h80, 8'h80, 1'b0));
    // overlapping ranges: lowest valid slot wins
    drive_item(ctl_load(3'd3, 32'd100, 8'd10, 1'b1));
    drive_item(ctl_load(3'd2, 32'd105, 8'd0, 1'b1));
    drive_item(ovr_load(8'd3, 8'd0, 32'd105, 16'h0001));
    drive_item(irq_op(FUNC_ROUTE_IRQ, 8'd3, 8'h55, 8'haa, 1'b0));
    drive_item(ovr_load(8'd4, 8'd0, 32'd110, 16'h000c));
    drive_item(irq_op(FUNC_ROUTE_IRQ, 8'd4, 8'haa, 8'h55, 1'b0));
    drive_item(irq_op(FUNC_MASK_IRQ, 8'd4, 8'h00, 8'h00, 1'b0));
    // slot written with valid_req low never matches
    drive_item(ctl_load(3'd0, 32'd0, 8'd23, 1'b0));
    drive_item(irq_op(FUNC_MASK_IRQ, 8'd0, 8'h00, 8'h00, 1'b1));
    drive_item(irq_op(FUNC_ROUTE_IRQ, 8'd0, 8'h10, 8'h01, 1'b0));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      drive_item(random_item());
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    do begin
      @(posedge clk_i);
    end while (pending_writes != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests (loads, routes, masks, misses, overrides, overlaps)",
             items_sent);
    $display("checked %0d register writes, with one %0d-cycle receiver hold-off",
             writes_checked, HOLD_LEN);
    if (mismatches == 0 && pending_writes == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
